// ===== design/rwve_pkg.sv =====
// Shared types and codes of the ring window velocity estimator.
// No dependencies; imported by the top level, rwve_ctrl, rwve_dpath and rwve_chk.
package rwve_pkg;

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_CALC  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FEW     = 2'd1,
		ST_ZERO_DT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDA,
		S_RDB,
		S_CHK,
		S_DIV,
		S_FIN,
		S_FDIV,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    add;
		logic    clr;
		logic    setup;
		logic    rd_a;
		logic    rd_b;
		logic    div_pair;
		logic    div_final;
		logic    acc;
		logic    load_out;
		status_t out_status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic few_samples;
		logic dt_zero;
		logic div_busy;
		logic last_pair;
	} sts_t;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned POS_W  = 32;
	localparam int unsigned VEL_W  = 48;
	// |dpos| * 256 fits in 41 bits
	localparam int unsigned PAIR_W = 41;

endpackage

// ===== design/ring_window_velocity_estimator.sv =====
// Ring window velocity estimator, top level. Holds up to MAX_SAMPLES timestamped
// positions (Q8) in a ring of window_size slots and answers a calc transaction with
// the mean of (pos[k+h]-pos[k])*256/(t[k+h]-t[k]) over the h = n/2 sample pairs, in Q16.
// Add and clear transactions give no result; a calc walks the pairs through the
// one-bit-per-cycle divider that every pair and the final mean share. Status 1 means
// fewer than two samples, 2 a zero time difference; velocity is then 0. Writing
// window_size empties the ring. The result sits in an output register; input is taken
// again as soon as it is loaded. Depends on rwve_pkg, rwve_ctrl, rwve_dpath, rwve_div.
module ring_window_velocity_estimator
	import rwve_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [4:0]              cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic signed [31:0]      position,
	input  logic [31:0]             timestamp,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [47:0]      velocity,
	output logic [1:0]              status
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: handshake and calc walk
	rwve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// ring store, divider, result register
	rwve_dpath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.position    (position),
		.timestamp   (timestamp),
		.cmd         (cmd),
		.sts         (sts),
		.velocity    (velocity),
		.status      (status)
	);

endmodule

// ===== design/rwve_div.sv =====
// Restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on nothing beyond its parameters.
module rwve_div #(
	parameter int unsigned DW = 44,
	parameter int unsigned VW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DW-1:0]        num_mag,
	input  logic                 num_neg,
	input  logic [VW-1:0]        den,
	output logic                 busy,
	output logic signed [DW:0]   quot
);

	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DW-1:0]     num_q;
	logic [VW-1:0]     rem_q;
	logic [VW-1:0]     den_q;
	logic              neg_q;
	logic [VW:0]       trial;
	logic              qbit;

	assign trial = {rem_q, num_q[DW-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num_mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num_neg;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], qbit};
			if (qbit)
				rem_q <= VW'(trial - {1'b0, den_q});
			else
				rem_q <= trial[VW-1:0];
		end
	end

	assign busy = busy_q;
	assign quot = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

// ===== design/rwve_ctrl.sv =====
// Sequencer of the velocity estimator: input handshake, calc walk, output register control.
// Uses rwve_pkg for the state, code and command types.
module rwve_ctrl
	import rwve_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  logic [1:0] action,
	output logic    out_valid,
	input  logic    out_stall,
	input  sts_t    sts,
	output cmd_t    cmd
);

	state_t  state_q, state_d;
	status_t stat_q, stat_d;
	logic    out_valid_q;
	logic    out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		stat_d  = stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && action == ACT_CALC) begin
					if (sts.few_samples) begin
						stat_d  = ST_FEW;
						state_d = S_OUT;
					end else begin
						stat_d  = ST_OK;
						state_d = S_RDA;
					end
				end
			end
			S_RDA: state_d = S_RDB;
			S_RDB: state_d = S_CHK;
			S_CHK: begin
				if (sts.dt_zero) begin
					stat_d  = ST_ZERO_DT;
					state_d = S_OUT;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (!sts.div_busy)
					state_d = sts.last_pair ? S_FIN : S_RDA;
			end
			S_FIN: state_d = S_FDIV;
			S_FDIV: begin
				if (!sts.div_busy)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action)
						ACT_ADD:   cmd.add   = 1'b1;
						ACT_CLEAR: cmd.clr   = 1'b1;
						ACT_CALC:  cmd.setup = !sts.few_samples;
						default:   ;
					endcase
				end
			end
			S_RDA:  cmd.rd_a      = 1'b1;
			S_RDB:  cmd.rd_b      = 1'b1;
			S_CHK:  cmd.div_pair  = !sts.dt_zero;
			S_DIV:  cmd.acc       = !sts.div_busy;
			S_FIN:  cmd.div_final = 1'b1;
			S_FDIV: ;
			S_OUT:  cmd.load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/rwve_dpath.sv =====
// Datapath: sample ring memory, ring pointers, pair walk, divider and result register.
// Uses rwve_pkg and rwve_div.
module rwve_dpath
	import rwve_pkg::*;
#(
	parameter int unsigned MAX_SAMPLES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [4:0]              cfg_wr_data,
	input  logic signed [POS_W-1:0] position,
	input  logic [TIME_W-1:0]       timestamp,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	output logic signed [VEL_W-1:0] velocity,
	output logic [1:0]              status
);

	localparam int unsigned IW = $clog2(MAX_SAMPLES);
	localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned DW = PAIR_W - 1 + IW + 1 - 1 + 1; // |sum| magnitude width
	localparam int unsigned SW = DW + 1;                     // signed sum width
	localparam int unsigned EW = POS_W + TIME_W;

	logic [EW-1:0] mem [MAX_SAMPLES];
	logic [EW-1:0] rd_q, sa_q;

	logic [IW-1:0] newest_q;
	logic [CW-1:0] fill_q, weff_q;
	logic [CW-1:0] h_q, cnt_q, a_q, b_q;
	logic signed [SW-1:0] sum_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [1:0] status_q;

	logic [CW-1:0] w_clamp, slot_d, newest_inc, oldest, a_inc, b_inc, h_d;
	logic [CW:0]   b_sum;
	logic [IW-1:0] wr_slot;

	logic [TIME_W-1:0] dt;
	logic signed [POS_W:0] dpos;
	logic [POS_W:0]    dpos_mag;

	logic              div_start, div_neg, div_busy;
	logic [DW-1:0]     div_num;
	logic [TIME_W-1:0] div_den;
	logic signed [DW:0] quot;
	logic [SW-1:0]     sum_mag;

	// window register clamp
	always_comb begin
		if (cfg_wr_data < 5'd2)
			w_clamp = CW'(2);
		else if (32'(cfg_wr_data) > MAX_SAMPLES)
			w_clamp = CW'(MAX_SAMPLES);
		else
			w_clamp = CW'(cfg_wr_data);
	end

	function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] v, input logic [CW-1:0] w);
		logic [CW:0] s;
		s = {1'b0, v} + 1'b1;
		wrap_inc = (s == {1'b0, w}) ? '0 : s[CW-1:0];
	endfunction

	assign newest_inc = wrap_inc(CW'(newest_q), weff_q);
	assign slot_d     = (fill_q < weff_q) ? fill_q : newest_inc;
	assign wr_slot    = slot_d[IW-1:0];

	assign oldest = (fill_q == weff_q) ? newest_inc : '0;
	assign h_d    = fill_q >> 1;
	assign b_sum  = {1'b0, oldest} + {1'b0, h_d};
	assign a_inc  = wrap_inc(a_q, weff_q);
	assign b_inc  = wrap_inc(b_q, weff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= IW'(MAX_SAMPLES - 1);
			fill_q   <= '0;
			weff_q   <= CW'(MAX_SAMPLES);
		end else if (cfg_wr_en) begin
			weff_q   <= w_clamp;
			newest_q <= IW'(MAX_SAMPLES - 1);
			fill_q   <= '0;
		end else if (cmd.clr) begin
			newest_q <= IW'(MAX_SAMPLES - 1);
			fill_q   <= '0;
		end else if (cmd.add) begin
			newest_q <= wr_slot;
			if (fill_q < weff_q)
				fill_q <= fill_q + 1'b1;
		end
	end

	// sample store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.add)
			mem[wr_slot] <= {position, timestamp};
		if (cmd.rd_a)
			rd_q <= mem[a_q[IW-1:0]];
		else if (cmd.rd_b)
			rd_q <= mem[b_q[IW-1:0]];
		if (cmd.rd_b)
			sa_q <= rd_q;
	end

	// pair walk
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			h_q   <= h_d;
			cnt_q <= '0;
			a_q   <= oldest;
			b_q   <= (b_sum >= {1'b0, weff_q}) ? CW'(b_sum - {1'b0, weff_q}) : b_sum[CW-1:0];
			sum_q <= '0;
		end else if (cmd.acc) begin
			cnt_q <= cnt_q + 1'b1;
			a_q   <= a_inc;
			b_q   <= b_inc;
			sum_q <= sum_q + SW'(quot);
		end
	end

	assign dt       = rd_q[TIME_W-1:0] - sa_q[TIME_W-1:0];
	assign dpos     = $signed({rd_q[EW-1], rd_q[EW-1:TIME_W]})
	                - $signed({sa_q[EW-1], sa_q[EW-1:TIME_W]});
	assign dpos_mag = dpos[POS_W] ? (POS_W+1)'(-dpos) : dpos;
	assign sum_mag  = sum_q[SW-1] ? SW'(-sum_q) : sum_q;

	always_comb begin
		div_start = cmd.div_pair || cmd.div_final;
		if (cmd.div_final) begin
			div_num = sum_mag[DW-1:0];
			div_neg = sum_q[SW-1];
			div_den = TIME_W'(h_q);
		end else begin
			div_num = DW'({dpos_mag, 8'd0});
			div_neg = dpos[POS_W];
			div_den = dt;
		end
	end

	rwve_div #(.DW(DW), .VW(TIME_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (div_num),
		.num_neg (div_neg),
		.den     (div_den),
		.busy    (div_busy),
		.quot    (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			vel_q    <= (cmd.out_status == ST_OK) ? VEL_W'(quot) : '0;
			status_q <= cmd.out_status;
		end
	end

	assign sts.few_samples = (fill_q < CW'(2));
	assign sts.dt_zero     = (dt == '0);
	assign sts.div_busy    = div_busy;
	assign sts.last_pair   = (cnt_q + 1'b1 == h_q);

	assign velocity = vel_q;
	assign status   = status_q;

endmodule

// ===== design/rwve_chk.sv =====
// Port-level checks of the velocity estimator, bound to the top level.
// Uses rwve_pkg for action and status codes.
module rwve_chk
	import rwve_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] velocity,
	input logic [1:0]  status
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(velocity) && $stable(status))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> velocity == '0)
		else $error("nonzero velocity with error status");

	// an accepted calc stalls input in the following cycle
	a_calc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_CALC |=> in_stall)
		else $error("calc did not stall input");

	a_add_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_ADD || action == ACT_CLEAR) |=> !in_stall)
		else $error("add or clear stalled input");

endmodule

bind ring_window_velocity_estimator rwve_chk u_chk (.*);
